### design/pdp11sfu_pkg.sv
package pdp11sfu_pkg;

    localparam logic [3:0] ACT_LD    = 4'd0;
    localparam logic [3:0] ACT_ST    = 4'd1;
    localparam logic [3:0] ACT_CLR   = 4'd2;
    localparam logic [3:0] ACT_ADD   = 4'd3;
    localparam logic [3:0] ACT_SUB   = 4'd4;
    localparam logic [3:0] ACT_MUL   = 4'd5;
    localparam logic [3:0] ACT_MODF  = 4'd6;
    localparam logic [3:0] ACT_DIV   = 4'd7;
    localparam logic [3:0] ACT_CMP   = 4'd8;
    localparam logic [3:0] ACT_TST   = 4'd9;
    localparam logic [3:0] ACT_NEG   = 4'd10;
    localparam logic [3:0] ACT_ABS   = 4'd11;
    localparam logic [3:0] ACT_LDEXP = 4'd12;
    localparam logic [3:0] ACT_STEXP = 4'd13;

    localparam logic [31:0]        NAN_BITS = 32'h7fc0_0000;
    localparam logic signed [11:0] E_MIN    = -12'sd149;
    localparam logic [3:0]         CF_Z     = 4'b0100;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_ADDSET, S_ALIGN, S_ADDSUM, S_MULSET, S_MUL,
        S_DIVSET, S_DIVPRE, S_DIV, S_NORM, S_ROUND, S_COMMIT, S_FIN
    } t_state;

    function automatic logic f_is_nan(input logic [31:0] b);
        return (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    endfunction

    function automatic logic f_is_inf(input logic [31:0] b);
        return b[30:0] == 31'h7f80_0000;
    endfunction

    function automatic logic f_is_zero(input logic [31:0] b);
        return b[30:0] == 31'd0;
    endfunction

    function automatic logic [23:0] f_mant(input logic [31:0] b);
        return {b[30:23] != 8'd0, b[22:0]};
    endfunction

    function automatic logic signed [11:0] f_exp(input logic [31:0] b);
        logic [7:0] e;
        e = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        return $signed({4'd0, e}) - 12'sd150;
    endfunction

    // Returns N, Z and V for a single value.
    function automatic logic [2:0] f_flags(input logic [31:0] b);
        logic nan;
        logic zero;
        nan  = f_is_nan(b);
        zero = f_is_zero(b);
        return {b[31] & !nan & !zero, zero, (b[30:0] > 31'h7eff_ffff) & !nan};
    endfunction

    // Returns greater-than and equal for an IEEE compare.
    function automatic logic [1:0] f_cmp(input logic [31:0] a, input logic [31:0] s);
        logic [31:0] ka;
        logic [31:0] ks;
        ka = f_is_zero(a) ? 32'h8000_0000 : (a[31] ? ~a : (a | 32'h8000_0000));
        ks = f_is_zero(s) ? 32'h8000_0000 : (s[31] ? ~s : (s | 32'h8000_0000));
        if (f_is_nan(a) || f_is_nan(s)) begin
            return 2'b00;
        end
        return {ka > ks, ka == ks};
    endfunction

    function automatic logic [31:0] f_from_pdp(input logic [15:0] hi, input logic [15:0] lo);
        logic [7:0]  e;
        logic [23:0] m;
        logic [23:0] q;
        logic        inc;
        logic [31:0] b;
        e   = hi[14:7];
        m   = {1'b1, hi[6:0], lo};
        q   = '0;
        inc = 1'b0;
        b   = '0;
        if (e == 8'd0) begin
            b = '0;
        end else if (e >= 8'd3) begin
            b = {hi[15], e - 8'd2, hi[6:0], lo};
        end else if (e == 8'd2) begin
            q   = {1'b0, m[23:1]};
            inc = m[0] & q[0];
            q   = q + {23'd0, inc};
            b   = {hi[15], 7'd0, q};
        end else begin
            q   = {2'b0, m[23:2]};
            inc = m[1] & (m[0] | q[0]);
            q   = q + {23'd0, inc};
            b   = {hi[15], 7'd0, q};
        end
        return b;
    endfunction

    // Returns the two F-format words, first word in the upper half.
    function automatic logic [31:0] f_to_pdp(input logic [31:0] b);
        logic [7:0]  e;
        logic [22:0] m;
        logic [31:0] r;
        e = b[30:23];
        m = b[22:0];
        r = '0;
        if (e == 8'hff && m != 23'd0) begin
            r = '0;
        end else if (e == 8'd0 && m == 23'd0) begin
            r = '0;
        end else if (e >= 8'd254) begin
            r = {b[31], 8'hff, 7'h7f, 16'hffff};
        end else if (e == 8'd0) begin
            if (m[22]) begin
                r = {b[31], 8'd2, m[21:0], 1'b0};
            end else if (m[21]) begin
                r = {b[31], 8'd1, m[20:0], 2'b0};
            end else begin
                r = '0;
            end
        end else begin
            r = {b[31], e + 8'd2, m};
        end
        return r;
    endfunction

    function automatic logic [31:0] f_trunc(input logic [31:0] b);
        logic [7:0]  e;
        logic [7:0]  sh;
        logic [31:0] r;
        e  = b[30:23];
        sh = 8'd150 - e;
        if (e >= 8'd150) begin
            r = b;
        end else if (e < 8'd127) begin
            r = {b[31], 31'd0};
        end else begin
            r = b & ~((32'd1 << sh[4:0]) - 32'd1);
        end
        return r;
    endfunction

endpackage

### design/pdp11_single_float_unit.sv
// Load, store, clear, compare, test, negate, absolute and the exponent operations go from
// decode straight to the result; add and subtract align, normalise and round, multiply and
// divide run one-bit-per-cycle loops, and modf adds an add pass to a multiply.
// Zero, infinite or NaN operands skip the loops.
// One item is in work at a time; the next is accepted in the cycle after its result is loaded.
// Synchronous active-low reset clears the accumulators, the condition flags and control.
module pdp11_single_float_unit
    import pdp11sfu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // action[3:0], acc_index[5:4], operand_is_reg[6], reg_index[9:7], src_high[25:10],
    // src_low[41:26], exponent_in[49:42], zero fill above.
    input  logic [55:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // flag_n[0], flag_z[1], flag_v[2], flag_c[3], mem_write[4], mem_high[20:5],
    // mem_low[36:21], exponent_out[44:37], zero fill above.
    output logic [47:0] o_m_axis_tdata
);

    t_state r_state, n_state;

    logic [3:0]  r_act;
    logic [1:0]  r_ac;
    logic        r_isreg;
    logic [2:0]  r_rg;
    logic [15:0] r_hi, r_lo;
    logic [7:0]  r_ex;

    logic [31:0] r_fmem [8];
    logic [7:0]  r_fvld;
    logic [31:0] r_rda, r_rdb;

    logic [31:0]        r_a, n_a, r_s, n_s, r_res, n_res;
    logic               r_sign, n_sign, r_ysign, n_ysign;
    logic signed [11:0] r_exp, n_exp, r_ye, n_ye;
    logic [48:0]        r_man, n_man;
    logic [26:0]        r_ym, n_ym;
    logic [23:0]        r_dv, n_dv;
    logic               r_guard, n_guard, r_sticky, n_sticky;
    logic [4:0]         r_cnt, n_cnt;
    logic               r_phase, n_phase;
    logic [3:0]         r_cf, n_cf;
    logic               r_mw, n_mw;
    logic [15:0]        r_mh, n_mh, r_ml, n_ml;
    logic [7:0]         r_eo, n_eo;

    logic        r_o_valid;
    logic [47:0] r_o_data;

    logic        w_accept, w_load;
    logic        w_we;
    logic [2:0]  w_waddr;
    logic [31:0] w_wdata;
    logic [31:0] w_src;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load          = (r_state == S_FIN) && (!r_o_valid || i_m_axis_tready);
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;
    assign w_src           = r_isreg ? r_rdb : f_from_pdp(r_hi, r_lo);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_fmem[w_waddr] <= w_wdata;
        end
        if (w_accept) begin
            r_rda <= r_fvld[{1'b0, i_s_axis_tdata[5:4]}] ?
                     r_fmem[{1'b0, i_s_axis_tdata[5:4]}] : 32'd0;
            r_rdb <= r_fvld[i_s_axis_tdata[9:7]] ? r_fmem[i_s_axis_tdata[9:7]] : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_fvld    <= '0;
            r_cf      <= '0;
        end else begin
            r_state <= n_state;
            r_cf    <= n_cf;
            if (w_we) begin
                r_fvld[w_waddr] <= 1'b1;
            end
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act   <= i_s_axis_tdata[3:0];
            r_ac    <= i_s_axis_tdata[5:4];
            r_isreg <= i_s_axis_tdata[6];
            r_rg    <= i_s_axis_tdata[9:7];
            r_hi    <= i_s_axis_tdata[25:10];
            r_lo    <= i_s_axis_tdata[41:26];
            r_ex    <= i_s_axis_tdata[49:42];
        end
        if (w_load) begin
            r_o_data <= {3'd0, r_eo, r_ml, r_mh, r_mw, r_cf[0], r_cf[1], r_cf[2], r_cf[3]};
        end
        r_a      <= n_a;
        r_s      <= n_s;
        r_res    <= n_res;
        r_sign   <= n_sign;
        r_ysign  <= n_ysign;
        r_exp    <= n_exp;
        r_ye     <= n_ye;
        r_man    <= n_man;
        r_ym     <= n_ym;
        r_dv     <= n_dv;
        r_guard  <= n_guard;
        r_sticky <= n_sticky;
        r_cnt    <= n_cnt;
        r_phase  <= n_phase;
        r_mw     <= n_mw;
        r_mh     <= n_mh;
        r_ml     <= n_ml;
        r_eo     <= n_eo;
    end

    always_comb begin
        logic [31:0]        x, y, v, tp;
        logic [2:0]         fl;
        logic [1:0]         cmp;
        logic               sg;
        logic [26:0]        mx, my, rem;
        logic signed [11:0] ex, ey, d, bexp;
        logic [27:0]        sum;
        logic [24:0]        acc, mr;
        logic               ge, inc;
        x    = '0;
        y    = '0;
        v    = '0;
        tp   = '0;
        fl   = '0;
        cmp  = '0;
        sg   = 1'b0;
        mx   = '0;
        my   = '0;
        rem  = '0;
        ex   = '0;
        ey   = '0;
        d    = '0;
        bexp = '0;
        sum  = '0;
        acc  = '0;
        mr   = '0;
        ge   = 1'b0;
        inc  = 1'b0;

        n_state  = r_state;
        n_a      = r_a;
        n_s      = r_s;
        n_res    = r_res;
        n_sign   = r_sign;
        n_ysign  = r_ysign;
        n_exp    = r_exp;
        n_ye     = r_ye;
        n_man    = r_man;
        n_ym     = r_ym;
        n_dv     = r_dv;
        n_guard  = r_guard;
        n_sticky = r_sticky;
        n_cnt    = r_cnt;
        n_phase  = r_phase;
        n_cf     = r_cf;
        n_mw     = r_mw;
        n_mh     = r_mh;
        n_ml     = r_ml;
        n_eo     = r_eo;
        w_we     = 1'b0;
        w_waddr  = {1'b0, r_ac};
        w_wdata  = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DECODE;
                    n_mw    = 1'b0;
                    n_mh    = '0;
                    n_ml    = '0;
                    n_eo    = '0;
                    n_phase = 1'b0;
                end
            end
            S_DECODE: begin
                n_a     = r_rda;
                n_s     = w_src;
                n_state = S_FIN;
                case (r_act)
                    ACT_LD: begin
                        fl      = f_flags(w_src);
                        w_we    = 1'b1;
                        w_wdata = w_src;
                        n_cf    = {fl[2:1], 2'b00};
                    end
                    ACT_ST: begin
                        if (r_isreg) begin
                            w_we    = 1'b1;
                            w_waddr = r_rg;
                            w_wdata = r_rda;
                        end else begin
                            tp   = f_to_pdp(r_rda);
                            n_mw = 1'b1;
                            n_mh = tp[31:16];
                            n_ml = tp[15:0];
                        end
                    end
                    ACT_CLR: begin
                        if (r_isreg) begin
                            w_we    = 1'b1;
                            w_waddr = r_rg;
                        end else begin
                            n_mw = 1'b1;
                        end
                        n_cf = CF_Z;
                    end
                    ACT_ADD, ACT_SUB: n_state = S_ADDSET;
                    ACT_MUL, ACT_MODF: n_state = S_MULSET;
                    ACT_DIV: n_state = S_DIVSET;
                    ACT_CMP: begin
                        cmp  = f_cmp(r_rda, w_src);
                        n_cf = {cmp, 2'b00};
                    end
                    ACT_TST: begin
                        fl   = f_flags(w_src);
                        n_cf = {fl[2:1], 2'b00};
                    end
                    ACT_NEG, ACT_ABS: begin
                        if (r_isreg) begin
                            v       = (r_act == ACT_NEG) ? (w_src ^ 32'h8000_0000) :
                                                           (w_src & 32'h7fff_ffff);
                            fl      = f_flags(v);
                            w_we    = 1'b1;
                            w_waddr = r_rg;
                            w_wdata = v;
                            n_cf    = {fl[2:1], 2'b00};
                        end else begin
                            n_mw = 1'b1;
                            if (r_hi[14:7] != 8'd0) begin
                                sg   = (r_act == ACT_NEG) ? !r_hi[15] : 1'b0;
                                n_mh = {sg, r_hi[14:0]};
                                n_ml = r_lo;
                                n_cf = {sg, 3'b000};
                            end else begin
                                n_cf = CF_Z;
                            end
                        end
                    end
                    ACT_LDEXP: begin
                        tp      = f_to_pdp(r_rda);
                        w_we    = 1'b1;
                        w_wdata = f_from_pdp({tp[31], r_ex ^ 8'h80, tp[22:16]}, tp[15:0]);
                    end
                    ACT_STEXP: begin
                        tp   = f_to_pdp(r_rda);
                        n_eo = tp[30:23] ^ 8'h80;
                    end
                    default: ;
                endcase
            end
            S_ADDSET: begin
                x       = r_a;
                y       = r_s ^ {(r_act != ACT_ADD), 31'd0};
                n_state = S_COMMIT;
                if (f_is_nan(x) || f_is_nan(y)) begin
                    n_res = NAN_BITS;
                end else if (f_is_inf(x) && f_is_inf(y) && (x[31] != y[31])) begin
                    n_res = NAN_BITS;
                end else if (f_is_inf(x)) begin
                    n_res = x;
                end else if (f_is_inf(y)) begin
                    n_res = y;
                end else if (f_is_zero(x) && f_is_zero(y)) begin
                    n_res = {x[31] & y[31], 31'd0};
                end else if (f_is_zero(x)) begin
                    n_res = y;
                end else if (f_is_zero(y)) begin
                    n_res = x;
                end else begin
                    mx = {f_mant(x), 3'b000};
                    my = {f_mant(y), 3'b000};
                    ex = f_exp(x) - 12'sd3;
                    ey = f_exp(y) - 12'sd3;
                    if (ex >= ey) begin
                        n_man   = {22'd0, mx};
                        n_exp   = ex;
                        n_sign  = x[31];
                        n_ym    = my;
                        n_ye    = ey;
                        n_ysign = y[31];
                        d       = ex - ey;
                    end else begin
                        n_man   = {22'd0, my};
                        n_exp   = ey;
                        n_sign  = y[31];
                        n_ym    = mx;
                        n_ye    = ex;
                        n_ysign = x[31];
                        d       = ey - ex;
                    end
                    if (d > 12'sd27) begin
                        n_ym = 27'd1;
                        n_ye = n_exp;
                    end
                    n_state = S_ALIGN;
                end
            end
            S_ALIGN: begin
                if (r_ye == r_exp) begin
                    n_state = S_ADDSUM;
                end else begin
                    n_ym = {1'b0, r_ym[26:1]} | {26'd0, r_ym[0]};
                    n_ye = r_ye + 12'sd1;
                end
            end
            S_ADDSUM: begin
                mx = r_man[26:0];
                sg = r_sign;
                if (r_sign == r_ysign) begin
                    sum = {1'b0, mx} + {1'b0, r_ym};
                end else if (mx >= r_ym) begin
                    sum = {1'b0, mx} - {1'b0, r_ym};
                end else begin
                    sum = {1'b0, r_ym} - {1'b0, mx};
                    sg  = r_ysign;
                end
                n_sign   = (sum == 28'd0) ? 1'b0 : sg;
                n_man    = {21'd0, sum};
                n_guard  = 1'b0;
                n_sticky = 1'b0;
                n_state  = S_NORM;
            end
            S_MULSET: begin
                x       = r_a;
                y       = r_s;
                sg      = x[31] ^ y[31];
                n_state = S_COMMIT;
                if (f_is_nan(x) || f_is_nan(y)) begin
                    n_res = NAN_BITS;
                end else if ((f_is_inf(x) && f_is_zero(y)) || (f_is_zero(x) && f_is_inf(y))) begin
                    n_res = NAN_BITS;
                end else if (f_is_inf(x) || f_is_inf(y)) begin
                    n_res = {sg, 8'hff, 23'd0};
                end else if (f_is_zero(x) || f_is_zero(y)) begin
                    n_res = {sg, 31'd0};
                end else begin
                    n_man    = {25'd0, f_mant(y)};
                    n_ym     = {3'd0, f_mant(x)};
                    n_exp    = f_exp(x) + f_exp(y);
                    n_sign   = sg;
                    n_cnt    = 5'd24;
                    n_guard  = 1'b0;
                    n_sticky = 1'b0;
                    n_state  = S_MUL;
                end
            end
            S_MUL: begin
                acc   = r_man[48:24] + (r_man[0] ? {1'b0, r_ym[23:0]} : 25'd0);
                n_man = {1'b0, acc, r_man[23:1]};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    n_state = S_NORM;
                end
            end
            S_DIVSET: begin
                x       = r_a;
                y       = r_s;
                sg      = x[31] ^ y[31];
                n_state = S_COMMIT;
                if (f_is_nan(x) || f_is_nan(y)) begin
                    n_res = NAN_BITS;
                end else if (f_is_zero(y)) begin
                    n_state = S_FIN;
                end else if (f_is_inf(x) && f_is_inf(y)) begin
                    n_res = NAN_BITS;
                end else if (f_is_inf(x)) begin
                    n_res = {sg, 8'hff, 23'd0};
                end else if (f_is_inf(y) || f_is_zero(x)) begin
                    n_res = {sg, 31'd0};
                end else begin
                    n_man    = {25'd0, f_mant(x)};
                    n_dv     = f_mant(y);
                    n_exp    = f_exp(x) - f_exp(y);
                    n_sign   = sg;
                    n_guard  = 1'b0;
                    n_sticky = 1'b0;
                    n_state  = S_DIVPRE;
                end
            end
            S_DIVPRE: begin
                if (r_man[23] && r_dv[23]) begin
                    n_ym    = {3'd0, r_man[23:0]};
                    n_man   = '0;
                    n_cnt   = 5'd27;
                    n_exp   = r_exp - 12'sd26;
                    n_state = S_DIV;
                end else begin
                    if (!r_man[23]) begin
                        n_man = {r_man[47:0], 1'b0};
                    end
                    if (!r_dv[23]) begin
                        n_dv = {r_dv[22:0], 1'b0};
                    end
                    n_exp = r_exp - $signed({11'd0, !r_man[23]}) + $signed({11'd0, !r_dv[23]});
                end
            end
            S_DIV: begin
                ge    = r_ym >= {3'd0, r_dv};
                rem   = ge ? (r_ym - {3'd0, r_dv}) : r_ym;
                n_ym  = {rem[25:0], 1'b0};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    n_man   = {r_man[47:0], ge | (rem != 27'd0)};
                    n_state = S_NORM;
                end else begin
                    n_man = {r_man[47:0], ge};
                end
            end
            S_NORM: begin
                if ((r_man[48:24] != 25'd0) || (r_exp < E_MIN)) begin
                    n_sticky = r_sticky | r_guard;
                    if (r_man == 49'd0) begin
                        n_guard = 1'b0;
                        n_exp   = E_MIN;
                    end else begin
                        n_man   = {1'b0, r_man[48:1]};
                        n_guard = r_man[0];
                        n_exp   = r_exp + 12'sd1;
                    end
                end else if (!r_man[23] && (r_man != 49'd0) && (r_exp > E_MIN)) begin
                    n_man   = {r_man[47:0], r_guard};
                    n_guard = 1'b0;
                    n_exp   = r_exp - 12'sd1;
                end else begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                inc = r_guard & (r_sticky | r_man[0]);
                mr  = {1'b0, r_man[23:0]} + {24'd0, inc};
                ex  = r_exp;
                if (mr[24]) begin
                    mr = {1'b0, mr[24:1]};
                    ex = ex + 12'sd1;
                end
                bexp = ex + 12'sd150;
                if (!mr[23]) begin
                    n_res = {r_sign, 8'd0, mr[22:0]};
                end else if (bexp >= 12'sd255) begin
                    n_res = {r_sign, 8'hff, 23'd0};
                end else begin
                    n_res = {r_sign, bexp[7:0], mr[22:0]};
                end
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                w_we = 1'b1;
                if ((r_act == ACT_MODF) && !r_phase) begin
                    v       = f_trunc(r_res);
                    w_waddr = {1'b0, r_ac[1], 1'b1};
                    w_wdata = v;
                    n_a     = r_res;
                    n_s     = v;
                    n_phase = 1'b1;
                    n_state = S_ADDSET;
                end else begin
                    fl      = f_flags(r_res);
                    w_wdata = r_res;
                    n_cf    = {fl, 1'b0};
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_o_valid || i_m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### dv/tb_pdp11_single_float_unit.sv
`timescale 1ns / 1ps

module tb_pdp11_single_float_unit;
    import pdp11sfu_pkg::*;

    typedef struct packed {
        logic [3:0]  act;
        logic [1:0]  ac;
        logic        isreg;
        logic [2:0]  rg;
        logic [15:0] hi;
        logic [15:0] lo;
        logic [7:0]  ex;
        logic        typed;
        logic [47:0] want;
    } t_row;

    localparam int N_RANDOM = 700;
    localparam int LIMIT    = 600000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [55:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [47:0] o_m_axis_tdata;

    logic [31:0] acc_bits [8];
    logic [3:0]  nzvc;
    logic [47:0] pending_results [$];
    t_row        directed [$];
    int          errors;
    int          in_count;
    int          out_count;
    int          cycles;
    int          hold_left;
    logic        hold_done;
    logic        stall_mode;
    int          mode_left;
    int          burst_left;
    t_row        item;

    pdp11_single_float_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic [31:0] round_to_single(input real x);
        logic [63:0] d;
        logic [63:0] sig;
        logic [63:0] m;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] val;
        logic        sgn;
        int          e;
        int          sh;
        d   = $realtobits(x);
        sgn = d[63];
        if (d[62:52] == 11'h7ff) begin
            return (d[51:0] != 0) ? NAN_BITS : {sgn, 8'hff, 23'd0};
        end
        if (d[62:52] == 11'd0) begin
            return {sgn, 31'd0};
        end
        e   = int'(d[62:52]) - 1023;
        sig = {11'd0, 1'b1, d[51:0]};
        sh  = (e >= -126) ? 29 : 29 + (-126 - e);
        if (sh > 60) begin
            return {sgn, 31'd0};
        end
        m    = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && m[0])) begin
            m = m + 64'd1;
        end
        if (e < -126) begin
            return {sgn, m[30:0]};
        end
        val = (64'(e + 127) << 23) + m - (64'd1 << 23);
        if (val >= 64'h7f80_0000) begin
            return {sgn, 31'h7f80_0000};
        end
        return {sgn, val[30:0]};
    endfunction

    function automatic real single_to_real(input logic [31:0] b);
        real r;
        if (b[30:23] == 8'hff) begin
            return $bitstoreal({b[31], 11'h7ff, b[22:0], 29'd0});
        end
        if (b[30:23] == 8'd0) begin
            r = real'(b[22:0]) * $bitstoreal({1'b0, 11'd874, 52'd0});
            return b[31] ? -r : r;
        end
        return $bitstoreal({b[31], {3'b000, b[30:23]} + 11'd896, b[22:0], 29'd0});
    endfunction

    function automatic logic [31:0] pdp_to_single(input logic [15:0] hi, input logic [15:0] lo);
        if (hi[14:7] == 8'd0) begin
            return 32'd0;
        end
        return round_to_single($bitstoreal({hi[15], {3'b000, hi[14:7]} + 11'd894,
                                            hi[6:0], lo, 29'd0}));
    endfunction

    function automatic logic [31:0] single_to_pdp(input logic [31:0] b);
        logic [7:0]  e;
        logic [22:0] m;
        logic [22:0] frac;
        int          p;
        e = b[30:23];
        m = b[22:0];
        if ((e == 8'hff && m != 0) || (e == 8'd0 && m == 0)) begin
            return 32'd0;
        end
        if (e >= 8'd254) begin
            return {b[31], 15'h7fff, 16'hffff};
        end
        if (e == 8'd0) begin
            p = 22;
            while (p > 0 && !m[p]) begin
                p--;
            end
            if (p < 21) begin
                return 32'd0;
            end
            frac = m << (23 - p);
            return {b[31], 8'(p - 20), frac};
        end
        return {b[31], e + 8'd2, m};
    endfunction

    function automatic logic [31:0] chop_fraction(input logic [31:0] b);
        logic [7:0] e;
        e = b[30:23];
        if (e >= 8'd150) begin
            return b;
        end
        if (e < 8'd127) begin
            return {b[31], 31'd0};
        end
        return b & ~((32'd1 << (8'd150 - e)) - 32'd1);
    endfunction

    function automatic logic is_nan(input logic [31:0] b);
        return b[30:23] == 8'hff && b[22:0] != 0;
    endfunction

    function automatic logic [3:0] value_flags(input logic [31:0] b, input logic with_v);
        logic z;
        z = b[30:0] == 31'd0;
        return {b[31] & !z & !is_nan(b), z,
                with_v & !is_nan(b) & (b[30:0] > 31'h7eff_ffff), 1'b0};
    endfunction

    function automatic logic [47:0] fpu_execute(input t_row r);
        logic [31:0] src;
        logic [31:0] res;
        logic [31:0] whole;
        logic [31:0] words;
        logic        mw;
        logic [15:0] mh;
        logic [15:0] ml;
        logic [7:0]  eo;
        real         a;
        real         s;
        src = r.isreg ? acc_bits[r.rg] : pdp_to_single(r.hi, r.lo);
        a   = single_to_real(acc_bits[r.ac]);
        s   = single_to_real(src);
        mw  = 1'b0;
        mh  = '0;
        ml  = '0;
        eo  = '0;
        case (r.act)
            ACT_LD: begin
                acc_bits[r.ac] = src;
                nzvc = value_flags(src, 1'b0);
            end
            ACT_ST: begin
                if (r.isreg) begin
                    acc_bits[r.rg] = acc_bits[r.ac];
                end else begin
                    mw = 1'b1;
                    {mh, ml} = single_to_pdp(acc_bits[r.ac]);
                end
            end
            ACT_CLR: begin
                if (r.isreg) begin
                    acc_bits[r.rg] = '0;
                end else begin
                    mw = 1'b1;
                end
                nzvc = CF_Z;
            end
            ACT_ADD, ACT_SUB, ACT_MUL: begin
                res = round_to_single(r.act == ACT_ADD ? a + s :
                                      r.act == ACT_SUB ? a - s : a * s);
                acc_bits[r.ac] = res;
                nzvc = value_flags(res, 1'b1);
            end
            ACT_MODF: begin
                res   = round_to_single(a * s);
                whole = chop_fraction(res);
                acc_bits[r.ac | 2'd1] = whole;
                acc_bits[r.ac] = round_to_single(single_to_real(res) - single_to_real(whole));
                nzvc = value_flags(acc_bits[r.ac], 1'b1);
            end
            ACT_DIV: begin
                if (s != 0.0) begin
                    acc_bits[r.ac] = round_to_single(a / s);
                    nzvc = value_flags(acc_bits[r.ac], 1'b1);
                end
            end
            ACT_CMP: nzvc = {a > s, a == s, 2'b00};
            ACT_TST: nzvc = value_flags(src, 1'b0);
            ACT_NEG, ACT_ABS: begin
                if (r.isreg) begin
                    res = (r.act == ACT_NEG) ? (src ^ 32'h8000_0000) : (src & 32'h7fff_ffff);
                    acc_bits[r.rg] = res;
                end else begin
                    mw = 1'b1;
                    if (r.hi[14:7] != 8'd0) begin
                        mh = (r.act == ACT_NEG) ? (r.hi ^ 16'h8000) : (r.hi & 16'h7fff);
                        ml = r.lo;
                    end
                    res = pdp_to_single(mh, ml);
                end
                nzvc = value_flags(res, 1'b0);
            end
            ACT_LDEXP: begin
                words = single_to_pdp(acc_bits[r.ac]);
                words[30:23] = r.ex + 8'd128;
                acc_bits[r.ac] = pdp_to_single(words[31:16], words[15:0]);
            end
            ACT_STEXP: begin
                words = single_to_pdp(acc_bits[r.ac]);
                eo = words[30:23] + 8'd128;
            end
            default: ;
        endcase
        return {3'b000, eo, ml, mh, mw, nzvc[0], nzvc[1], nzvc[2], nzvc[3]};
    endfunction

    function automatic t_row mk(input logic [3:0] act, input logic [1:0] ac, input logic isreg,
                                input logic [2:0] rg, input logic [15:0] hi,
                                input logic [15:0] lo, input logic [7:0] ex,
                                input logic typed, input logic [47:0] want);
        t_row r;
        r = '{act, ac, isreg, rg, hi, lo, ex, typed, want};
        return r;
    endfunction

    function automatic logic [15:0] random_high();
        logic [15:0] h;
        h = 16'($urandom);
        if ($urandom_range(0, 9) < 7) begin
            h[14:7] = 8'($urandom_range(118, 140));
        end else if ($urandom_range(0, 3) == 0) begin
            h[14:7] = 8'($urandom_range(0, 3));
        end
        return h;
    endfunction

    function automatic t_row random_item();
        t_row r;
        r.act   = 4'($urandom_range(ACT_LD, ACT_STEXP));
        r.ac    = 2'($urandom);
        r.isreg = 1'($urandom);
        r.rg    = 3'($urandom);
        r.hi    = random_high();
        r.lo    = 16'($urandom);
        r.ex    = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8) - 4);
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding.", cycles,
                     pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            hold_left       <= 0;
            hold_done       <= 1'b0;
            stall_mode      <= 1'b0;
            mode_left       <= 50;
        end else begin
            mode_left <= (mode_left == 0) ? $urandom_range(20, 120) : mode_left - 1;
            if (mode_left == 0) begin
                stall_mode <= 1'($urandom);
            end
            if (hold_left != 0) begin
                i_m_axis_tready <= 1'b0;
                hold_left       <= hold_left - 1;
            end else if (!hold_done && in_count >= 200) begin
                i_m_axis_tready <= 1'b0;
                hold_left       <= 500;
                hold_done       <= 1'b1;
            end else begin
                i_m_axis_tready <= !stall_mode || ($urandom_range(0, 3) != 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            out_count <= out_count + 1;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item %h", $realtime, o_m_axis_tdata);
                errors <= errors + 1;
            end else if (pending_results[0] !== o_m_axis_tdata) begin
                $display("%0t: mismatch, expected nzvc %b%b%b%b w %b hi %h lo %h exp %h",
                         $realtime, pending_results[0][0], pending_results[0][1],
                         pending_results[0][2], pending_results[0][3], pending_results[0][4],
                         pending_results[0][20:5], pending_results[0][36:21],
                         pending_results[0][44:37]);
                $display("%0t:           actual nzvc %b%b%b%b w %b hi %h lo %h exp %h",
                         $realtime, o_m_axis_tdata[0], o_m_axis_tdata[1], o_m_axis_tdata[2],
                         o_m_axis_tdata[3], o_m_axis_tdata[4], o_m_axis_tdata[20:5],
                         o_m_axis_tdata[36:21], o_m_axis_tdata[47:37]);
                errors <= errors + 1;
                void'(pending_results.pop_front());
            end else begin
                void'(pending_results.pop_front());
            end
        end
    end

    task automatic send_item(input t_row r);
        logic [47:0] predicted;
        if (burst_left == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 25);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'd0, r.ex, r.lo, r.hi, r.rg, r.isreg, r.ac, r.act};
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        predicted = fpu_execute(r);
        pending_results.push_back(r.typed ? r.want : predicted);
        in_count++;
    endtask

    initial begin
        errors          = 0;
        in_count        = 0;
        out_count       = 0;
        cycles          = 0;
        burst_left      = 0;
        nzvc            = '0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        for (int i = 0; i < 8; i++) begin
            acc_bits[i] = '0;
        end

        // The first rows run from reset, so their results can be typed in directly.
        directed.push_back(mk(ACT_TST,   0, 1, 0, 16'h0000, 16'h0000, 8'h00, 1, 48'h2));
        directed.push_back(mk(ACT_CLR,   0, 0, 0, 16'h0000, 16'h0000, 8'h00, 1, 48'h12));
        directed.push_back(mk(ACT_ST,    0, 0, 0, 16'h0000, 16'h0000, 8'h00, 1, 48'h12));
        directed.push_back(mk(ACT_STEXP, 0, 1, 0, 16'h0000, 16'h0000, 8'h00, 1,
                              {3'd0, 8'd128, 32'd0, 5'h2}));
        directed.push_back(mk(ACT_LD,    1, 0, 0, 16'h7fff, 16'hffff, 8'h00, 1, 48'h0));
        directed.push_back(mk(ACT_ST,    1, 0, 0, 16'h0000, 16'h0000, 8'h00, 1,
                              {11'd0, 16'hffff, 16'h7fff, 5'h10}));
        directed.push_back(mk(ACT_NEG,   0, 0, 0, 16'h0000, 16'hffff, 8'h00, 1, 48'h12));
        directed.push_back(mk(ACT_MUL,   1, 1, 1, 16'h0000, 16'h0000, 8'h00, 0, 48'h0));
        directed.push_back(mk(ACT_STEXP, 1, 1, 0, 16'h0000, 16'h0000, 8'h00, 0, 48'h0));
        directed.push_back(mk(ACT_LD,    2, 0, 0, 16'hc0ab, 16'h1234, 8'h00, 0, 48'h0));
        directed.push_back(mk(ACT_LD,    3, 0, 0, 16'h40c0, 16'h0000, 8'h00, 0, 48'h0));
        directed.push_back(mk(ACT_ADD,   2, 1, 3, 16'h0000, 16'h0000, 8'h00, 0, 48'h0));
        directed.push_back(mk(ACT_SUB,   3, 0, 0, 16'h40c0, 16'h0000, 8'h00, 0, 48'h0));
        directed.push_back(mk(ACT_LD,    0, 0, 0, 16'h4149, 16'h0fdb, 8'h00, 0, 48'h0));
        directed.push_back(mk(ACT_MODF,  1, 0, 0, 16'h4220, 16'h0000, 8'h00, 0, 48'h0));
        directed.push_back(mk(ACT_MODF,  2, 1, 0, 16'h0000, 16'h0000, 8'h00, 0, 48'h0));
        directed.push_back(mk(ACT_DIV,   0, 0, 0, 16'h0000, 16'h0000, 8'h00, 0, 48'h0));
        directed.push_back(mk(ACT_DIV,   0, 0, 0, 16'hc140, 16'h0000, 8'h00, 0, 48'h0));
        directed.push_back(mk(ACT_CMP,   0, 1, 2, 16'h0000, 16'h0000, 8'h00, 0, 48'h0));
        directed.push_back(mk(ACT_ABS,   0, 0, 0, 16'hffff, 16'hffff, 8'h00, 0, 48'h0));
        directed.push_back(mk(ACT_NEG,   0, 1, 2, 16'h0000, 16'h0000, 8'h00, 0, 48'h0));
        directed.push_back(mk(ACT_LD,    3, 0, 0, 16'h0155, 16'haaaa, 8'h00, 0, 48'h0));
        directed.push_back(mk(ACT_LDEXP, 0, 0, 0, 16'h0000, 16'h0000, 8'h80, 0, 48'h0));
        directed.push_back(mk(ACT_LDEXP, 2, 1, 0, 16'h0000, 16'h0000, 8'h7f, 0, 48'h0));
        directed.push_back(mk(ACT_TST,   0, 0, 0, 16'h80c0, 16'h0001, 8'h00, 0, 48'h0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            send_item(directed[i]);
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            item = random_item();
            send_item(item);
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (100) @(posedge i_clk);

        $display("Ran %0d float instructions (%0d directed, %0d random) over all fourteen",
                 in_count, directed.size(), N_RANDOM);
        $display("operations with register and memory operands; %0d results checked.",
                 out_count);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
